// File: rtl/kes_pkg.sv
package kes_pkg;

	// Default table dimensions
	localparam int NUM_COLLECTIVES_DEF = 8;
	localparam int NUM_REDUCE_OPS_DEF  = 5;
	localparam int NUM_DATA_TYPES_DEF  = 10;
	localparam int NUM_ALGORITHMS_DEF  = 6;
	localparam int NUM_PROTOCOLS_DEF   = 3;
	localparam int NUM_SIZE_BINS_DEF   = 32;

	// Sizes whose top set bit is at or below this index land in bin 0
	localparam int SMALL_MSB_LIMIT = 9;

	// Function codes
	localparam logic FUNC_RECORD = 1'b0;
	localparam logic FUNC_READ   = 1'b1;

	// Read word codes
	localparam logic [5:0] WORD_OPS    = 6'd0;
	localparam logic [5:0] WORD_BYTES  = 6'd1;
	localparam logic [5:0] WORD_CHUNKS = 6'd2;
	localparam logic [5:0] WORD_BIN0   = 6'd3;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MUL_OP,
		ST_MUL_DT,
		ST_MUL_ALG,
		ST_MUL_PROT,
		ST_ADDR,
		ST_READ,
		ST_WRITE,
		ST_DONE
	} state_t;

	// Which factor and addend the shared index multiplier uses
	typedef enum logic [2:0] {
		STEP_OP,
		STEP_DT,
		STEP_ALG,
		STEP_PROT,
		STEP_BIN
	} step_t;

	typedef struct packed {
		logic  clear;
		logic  capture;
		logic  mul_en;
		step_t step;
		logic  commit;
		logic  load_out;
	} cmd_t;

endpackage

// File: rtl/kes_ram.sv
module kes_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 2,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// File: rtl/kes_ctrl.sv
module kes_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	input  logic          clr_last,
	output kes_pkg::cmd_t cmd
);

	import kes_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) state_d = ST_MUL_OP;
			end
			ST_MUL_OP:   state_d = ST_MUL_DT;
			ST_MUL_DT:   state_d = ST_MUL_ALG;
			ST_MUL_ALG:  state_d = ST_MUL_PROT;
			ST_MUL_PROT: state_d = ST_ADDR;
			ST_ADDR:     state_d = ST_READ;
			ST_READ:     state_d = ST_WRITE;
			ST_WRITE:    state_d = ST_DONE;
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default:     state_d = ST_CLEAR;
		endcase
	end

	// Datapath commands
	always_comb begin
		cmd = '0;
		cmd.step = STEP_OP;
		unique case (state_q)
			ST_CLEAR:    cmd.clear = 1'b1;
			ST_IDLE:     cmd.capture = in_valid;
			ST_MUL_OP: begin
				cmd.mul_en = 1'b1;
				cmd.step = STEP_OP;
			end
			ST_MUL_DT: begin
				cmd.mul_en = 1'b1;
				cmd.step = STEP_DT;
			end
			ST_MUL_ALG: begin
				cmd.mul_en = 1'b1;
				cmd.step = STEP_ALG;
			end
			ST_MUL_PROT: begin
				cmd.mul_en = 1'b1;
				cmd.step = STEP_PROT;
			end
			ST_ADDR: begin
				cmd.mul_en = 1'b1;
				cmd.step = STEP_BIN;
			end
			ST_READ:     cmd.commit = 1'b0;
			ST_WRITE:    cmd.commit = 1'b1;
			ST_DONE:     cmd.load_out = out_free;
			default:     cmd.clear = 1'b0;
		endcase
	end

	// State and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: rtl/kes_dp.sv
module kes_dp #(
	parameter int NUM_COLLECTIVES = kes_pkg::NUM_COLLECTIVES_DEF,
	parameter int NUM_REDUCE_OPS  = kes_pkg::NUM_REDUCE_OPS_DEF,
	parameter int NUM_DATA_TYPES  = kes_pkg::NUM_DATA_TYPES_DEF,
	parameter int NUM_ALGORITHMS  = kes_pkg::NUM_ALGORITHMS_DEF,
	parameter int NUM_PROTOCOLS   = kes_pkg::NUM_PROTOCOLS_DEF,
	parameter int NUM_SIZE_BINS   = kes_pkg::NUM_SIZE_BINS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  kes_pkg::cmd_t cmd,
	output logic          clr_last,
	input  logic          func,
	input  logic [3:0]    collective,
	input  logic [7:0]    reduce_op,
	input  logic [3:0]    data_type,
	input  logic [2:0]    algorithm,
	input  logic [1:0]    protocol,
	input  logic [63:0]   byte_count,
	input  logic [31:0]   chunk_count,
	input  logic [5:0]    read_word,
	output logic [63:0]   read_data,
	output logic          in_range
);

	import kes_pkg::*;

	localparam int NUM_ENTRIES = NUM_COLLECTIVES * NUM_REDUCE_OPS * NUM_DATA_TYPES
		* NUM_ALGORITHMS * NUM_PROTOCOLS;
	localparam int ENTRY_AW   = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
	localparam int BIN_DEPTH  = NUM_ENTRIES * NUM_SIZE_BINS;
	localparam int BIN_AW     = $clog2(BIN_DEPTH);
	localparam int BIN_W      = $clog2(NUM_SIZE_BINS);
	localparam int WORD_LIMIT = int'(WORD_BIN0) + NUM_SIZE_BINS;

	// Captured transaction
	logic                func_q;
	logic [7:0]          op_q;
	logic [3:0]          dt_q;
	logic [2:0]          alg_q;
	logic [1:0]          prot_q;
	logic [63:0]         bytes_q;
	logic [31:0]         chunks_q;
	logic [5:0]          word_q;
	logic                idx_ok_q;
	logic [2:0]          grp_q;
	logic [7:0]          grp_byte_q;

	logic [BIN_W-1:0]    bin_q;
	logic [ENTRY_AW-1:0] acc_q;
	logic [BIN_AW-1:0]   bin_addr_q;
	logic [BIN_AW-1:0]   clr_q;
	logic [63:0]         res_data_q;
	logic                res_ok_q;
	logic [63:0]         read_data_q;
	logic                in_range_q;

	logic                idx_ok;
	logic [2:0]          grp;
	logic [7:0]          grp_byte;
	logic [2:0]          pos;
	logic [5:0]          msb;
	logic [BIN_W-1:0]    bin;
	logic [BIN_AW-1:0]   factor;
	logic [BIN_AW-1:0]   addend;
	logic [BIN_AW-1:0]   mul_sum;
	logic                word_ok;
	logic                ok_now;
	logic                wr_rec;
	logic [63:0]         sel_data;

	logic                small_we;
	logic [ENTRY_AW-1:0] small_waddr;
	logic                bin_we;
	logic [BIN_AW-1:0]   bin_waddr;
	logic [63:0]         ops_rd;
	logic [63:0]         bytes_rd;
	logic [63:0]         chunks_rd;
	logic [63:0]         bin_rd;
	logic [63:0]         ops_wd;
	logic [63:0]         bytes_wd;
	logic [63:0]         chunks_wd;
	logic [63:0]         bin_wd;

	// Check every index against its table dimension
	assign idx_ok = (32'(collective) < NUM_COLLECTIVES)
		&& (32'(reduce_op) < NUM_REDUCE_OPS)
		&& (32'(data_type) < NUM_DATA_TYPES)
		&& (32'(algorithm) < NUM_ALGORITHMS)
		&& (32'(protocol) < NUM_PROTOCOLS);

	// Find the highest nonzero byte of the size
	always_comb begin
		grp = '0;
		grp_byte = byte_count[7:0];
		for (int g = 1; g < 8; g++) begin
			if (|byte_count[8*g +: 8]) begin
				grp = 3'(g);
				grp_byte = byte_count[8*g +: 8];
			end
		end
	end

	// Finish the leading-one search inside the byte and map it to a bin
	always_comb begin
		pos = '0;
		for (int b = 1; b < 8; b++) begin
			if (grp_byte_q[b]) pos = 3'(b);
		end
		msb = {grp_q, pos};
		if (32'(msb) <= SMALL_MSB_LIMIT) begin
			bin = '0;
		end else if (32'(msb) - SMALL_MSB_LIMIT > NUM_SIZE_BINS - 1) begin
			bin = BIN_W'(NUM_SIZE_BINS - 1);
		end else begin
			bin = BIN_W'(32'(msb) - SMALL_MSB_LIMIT);
		end
	end

	// Shared index multiplier: one mixed-radix digit per step
	always_comb begin
		unique case (cmd.step)
			STEP_OP: begin
				factor = BIN_AW'(NUM_REDUCE_OPS);
				addend = BIN_AW'(op_q);
			end
			STEP_DT: begin
				factor = BIN_AW'(NUM_DATA_TYPES);
				addend = BIN_AW'(dt_q);
			end
			STEP_ALG: begin
				factor = BIN_AW'(NUM_ALGORITHMS);
				addend = BIN_AW'(alg_q);
			end
			STEP_PROT: begin
				factor = BIN_AW'(NUM_PROTOCOLS);
				addend = BIN_AW'(prot_q);
			end
			STEP_BIN: begin
				factor = BIN_AW'(NUM_SIZE_BINS);
				addend = (func_q == FUNC_READ) ? BIN_AW'(word_q - WORD_BIN0)
					: BIN_AW'(bin_q);
			end
			default: begin
				factor = '0;
				addend = '0;
			end
		endcase
	end

	assign mul_sum = BIN_AW'(acc_q) * factor + addend;

	// Result and write-back decisions
	assign word_ok = (32'(word_q) < WORD_LIMIT);
	assign ok_now  = idx_ok_q && ((func_q == FUNC_RECORD) || word_ok);
	assign wr_rec  = cmd.commit && (func_q == FUNC_RECORD) && idx_ok_q;

	always_comb begin
		case (word_q)
			WORD_OPS:    sel_data = ops_rd;
			WORD_BYTES:  sel_data = bytes_rd;
			WORD_CHUNKS: sel_data = chunks_rd;
			default:     sel_data = bin_rd;
		endcase
	end

	// Memory write muxing: clearing pass or counter update
	assign small_we    = cmd.clear ? (32'(clr_q) < NUM_ENTRIES) : wr_rec;
	assign small_waddr = cmd.clear ? ENTRY_AW'(clr_q) : acc_q;
	assign bin_we      = cmd.clear || wr_rec;
	assign bin_waddr   = cmd.clear ? clr_q : bin_addr_q;
	assign ops_wd      = cmd.clear ? '0 : ops_rd + 64'd1;
	assign bytes_wd    = cmd.clear ? '0 : bytes_rd + bytes_q;
	assign chunks_wd   = cmd.clear ? '0 : chunks_rd + 64'(chunks_q);
	assign bin_wd      = cmd.clear ? '0 : bin_rd + 64'd1;

	assign clr_last = (clr_q == BIN_AW'(BIN_DEPTH - 1));

	kes_ram #(.WIDTH(64), .DEPTH(NUM_ENTRIES)) u_ops_ram (
		.clk     (clk),
		.wr_en   (small_we),
		.wr_addr (small_waddr),
		.wr_data (ops_wd),
		.rd_addr (acc_q),
		.rd_data (ops_rd)
	);

	kes_ram #(.WIDTH(64), .DEPTH(NUM_ENTRIES)) u_bytes_ram (
		.clk     (clk),
		.wr_en   (small_we),
		.wr_addr (small_waddr),
		.wr_data (bytes_wd),
		.rd_addr (acc_q),
		.rd_data (bytes_rd)
	);

	kes_ram #(.WIDTH(64), .DEPTH(NUM_ENTRIES)) u_chunks_ram (
		.clk     (clk),
		.wr_en   (small_we),
		.wr_addr (small_waddr),
		.wr_data (chunks_wd),
		.rd_addr (acc_q),
		.rd_data (chunks_rd)
	);

	kes_ram #(.WIDTH(64), .DEPTH(BIN_DEPTH)) u_bin_ram (
		.clk     (clk),
		.wr_en   (bin_we),
		.wr_addr (bin_waddr),
		.wr_data (bin_wd),
		.rd_addr (bin_addr_q),
		.rd_data (bin_rd)
	);

	// Advance the clearing address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear) begin
			clr_q <= clr_q + BIN_AW'(1);
		end
	end

	// Capture the transaction, build the addresses, hold the result
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q     <= func;
			op_q       <= reduce_op;
			dt_q       <= data_type;
			alg_q      <= algorithm;
			prot_q     <= protocol;
			bytes_q    <= byte_count;
			chunks_q   <= chunk_count;
			word_q     <= read_word;
			idx_ok_q   <= idx_ok;
			grp_q      <= grp;
			grp_byte_q <= grp_byte;
			acc_q      <= ENTRY_AW'(collective);
		end
		if (cmd.mul_en) begin
			if (cmd.step == STEP_BIN) begin
				bin_addr_q <= mul_sum;
			end else begin
				acc_q <= ENTRY_AW'(mul_sum);
			end
			if (cmd.step == STEP_OP) begin
				bin_q <= bin;
			end
		end
		if (cmd.commit) begin
			res_data_q <= ((func_q == FUNC_READ) && ok_now) ? sel_data : '0;
			res_ok_q   <= ok_now;
		end
		if (cmd.load_out) begin
			read_data_q <= res_data_q;
			in_range_q  <= res_ok_q;
		end
	end

	assign read_data = read_data_q;
	assign in_range  = in_range_q;

endmodule

// File: rtl/keyed_event_stats_with_log2_histogram.sv
// Channel  Handshake            Payload
// in       in_valid, in_stall   func, collective, reduce_op, data_type, algorithm,
//                               protocol, byte_count, chunk_count, read_word
// out      out_valid, out_stall read_data, in_range
//
// A new transaction is taken only once the last is through: four steps of the shared
// index multiplier, one step for the size-bin address, then read, update and result
// hand-off over the single read and write port of each counter memory.
// After reset a clearing pass zeroes the memories, one address per cycle, over all
// NUM_ENTRIES * NUM_SIZE_BINS addresses (230400 at the defaults); in_stall stays high.
// A finished result waits in the output register while the next transaction is
// taken; a result held longer by out_stall keeps the block from finishing the next.
module keyed_event_stats_with_log2_histogram #(
	parameter int NUM_COLLECTIVES = kes_pkg::NUM_COLLECTIVES_DEF,
	parameter int NUM_REDUCE_OPS  = kes_pkg::NUM_REDUCE_OPS_DEF,
	parameter int NUM_DATA_TYPES  = kes_pkg::NUM_DATA_TYPES_DEF,
	parameter int NUM_ALGORITHMS  = kes_pkg::NUM_ALGORITHMS_DEF,
	parameter int NUM_PROTOCOLS   = kes_pkg::NUM_PROTOCOLS_DEF,
	parameter int NUM_SIZE_BINS   = kes_pkg::NUM_SIZE_BINS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        func,
	input  logic [3:0]  collective,
	input  logic [7:0]  reduce_op,
	input  logic [3:0]  data_type,
	input  logic [2:0]  algorithm,
	input  logic [1:0]  protocol,
	input  logic [63:0] byte_count,
	input  logic [31:0] chunk_count,
	input  logic [5:0]  read_word,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] read_data,
	output logic        in_range
);

	import kes_pkg::*;

	cmd_t cmd;
	logic clr_last;

	kes_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.clr_last  (clr_last),
		.cmd       (cmd)
	);

	kes_dp #(
		.NUM_COLLECTIVES (NUM_COLLECTIVES),
		.NUM_REDUCE_OPS  (NUM_REDUCE_OPS),
		.NUM_DATA_TYPES  (NUM_DATA_TYPES),
		.NUM_ALGORITHMS  (NUM_ALGORITHMS),
		.NUM_PROTOCOLS   (NUM_PROTOCOLS),
		.NUM_SIZE_BINS   (NUM_SIZE_BINS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.clr_last    (clr_last),
		.func        (func),
		.collective  (collective),
		.reduce_op   (reduce_op),
		.data_type   (data_type),
		.algorithm   (algorithm),
		.protocol    (protocol),
		.byte_count  (byte_count),
		.chunk_count (chunk_count),
		.read_word   (read_word),
		.read_data   (read_data),
		.in_range    (in_range)
	);

endmodule
